// ===== hw/rtl/trst_pkg.sv =====
// trst_pkg: shared types, sizes and codes of the time range schedule table
// no dependencies; imported by the table unit, the compare unit and the testbench files
`default_nettype none

package trst_pkg;

   localparam int MaxEntries = 16;
   localparam int AddrW      = 4;
   localparam int CntW       = 5;
   localparam int TimeW      = 27;
   localparam int SpeedW     = 31;

   // operation codes
   localparam logic [3:0] OP_ADD       = 4'd0;
   localparam logic [3:0] OP_REMOVE    = 4'd1;
   localparam logic [3:0] OP_CLEAR     = 4'd2;
   localparam logic [3:0] OP_SET_START = 4'd3;
   localparam logic [3:0] OP_SET_END   = 4'd4;
   localparam logic [3:0] OP_SET_DOWN  = 4'd5;
   localparam logic [3:0] OP_SET_UP    = 4'd6;
   localparam logic [3:0] OP_SET_PAUSE = 4'd7;
   localparam logic [3:0] OP_LOOKUP    = 4'd8;
   localparam logic [3:0] OP_READ      = 4'd9;

   // overlap codes
   localparam logic [1:0] CONF_NONE  = 2'd0;
   localparam logic [1:0] CONF_START = 2'd1;
   localparam logic [1:0] CONF_END   = 2'd2;
   localparam logic [1:0] CONF_BOTH  = 2'd3;

   typedef struct packed {
      logic [3:0]        op;
      logic [3:0]        index;
      logic [TimeW-1:0]  start_time;
      logic [TimeW-1:0]  end_time;
      logic [SpeedW-1:0] download_speed;
      logic [SpeedW-1:0] upload_speed;
      logic              pause_flag;
      logic [TimeW-1:0]  now_time;
   } req_type;

   typedef struct packed {
      logic              accepted;
      logic [1:0]        conflict;
      logic              updated;
      logic [3:0]        hit_index;
      logic [CntW-1:0]   entry_count;
      logic [TimeW-1:0]  out_start;
      logic [TimeW-1:0]  out_end;
      logic [SpeedW-1:0] out_download;
      logic [SpeedW-1:0] out_upload;
      logic              out_pause;
   } rsp_type;

   typedef struct packed {
      logic [TimeW-1:0]  start_ms;
      logic [TimeW-1:0]  end_ms;
      logic [SpeedW-1:0] down;
      logic [SpeedW-1:0] up;
      logic              pause;
   } entry_type;

   // compare results of probes a and b against an entry's start s and end e
   typedef struct packed {
      logic a_lt_s;
      logic a_eq_s;
      logic a_lt_e;
      logic a_eq_e;
      logic b_lt_s;
      logic b_eq_s;
      logic b_lt_e;
      logic b_eq_e;
   } cmp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_RD,
      ST_EV,
      ST_SHRD,
      ST_SHWR,
      ST_WR,
      ST_FIN
   } state_type;

endpackage

`default_nettype wire

// ===== hw/rtl/time_range_schedule_table_unit.sv =====
// Time range schedule table: sequencer over one entry RAM and one compare unit.
// Clear and rejects go straight to the result; read and field edits read and evaluate the entry,
// start/end edits that check a neighbor read and evaluate it too; add and lookup scan entries
// (read, evaluate each), add and remove move entries (read, write each); add then writes the insert.
// One operation at a time; the next transfer is taken the cycle after the result is latched.
// Synchronous active-high reset empties the table; entry storage is not cleared.
`default_nettype none

module time_range_schedule_table_unit
   import trst_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_data
);

   state_type         state_ff, state_in, go_state;
   req_type           req_ff, req_in;
   logic [CntW-1:0]   count_ff, count_in;
   logic [AddrW-1:0]  ptr_ff, ptr_in;
   logic [AddrW-1:0]  pos_ff, pos_in;
   logic              found_ff, found_in;
   logic [1:0]        code_ff, code_in;
   logic              phase_ff, phase_in;
   entry_type         ent_ff, ent_in;
   logic              acc_ff, acc_in;
   logic              upd_ff, upd_in;
   logic [AddrW-1:0]  hit_ff, hit_in;
   entry_type         out_ff, out_in;
   logic              rsp_valid_ff;
   rsp_type           rsp_data_ff;

   logic              ram_we;
   logic [AddrW-1:0]  ram_waddr;
   logic [AddrW-1:0]  ram_raddr;
   entry_type         ram_wdata;
   entry_type         ram_rdata;
   cmp_type           cmp;
   logic [TimeW-1:0]  probe_a;

   trst_ram #(
      .Width($bits(entry_type)),
      .Depth(MaxEntries)
   ) u_ram (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(ram_waddr),
      .wr_data(ram_wdata),
      .rd_addr(ram_raddr),
      .rd_data(ram_rdata)
   );

   assign probe_a = (req_ff.op == OP_LOOKUP) ? req_ff.now_time : req_ff.start_time;

   trst_cmp u_cmp (
      .probe_a  (probe_a),
      .probe_b  (req_ff.end_time),
      .ent_start(ram_rdata.start_ms),
      .ent_end  (ram_rdata.end_ms),
      .flags    (cmp)
   );

   // read address: remove moves entry ptr+1 down to ptr
   assign ram_raddr = (state_ff == ST_SHRD && req_ff.op == OP_REMOVE)
                      ? AddrW'(ptr_ff + AddrW'(1)) : ptr_ff;

   // datapath, RAM writes and branch decisions
   always_comb begin
      logic in_rng;
      logic last;
      logic so, eo, enc;
      logic [1:0] code_nx;
      logic [AddrW-1:0] pos_nx;
      req_in   = req_ff;
      count_in = count_ff;
      ptr_in   = ptr_ff;
      pos_in   = pos_ff;
      found_in = found_ff;
      code_in  = code_ff;
      phase_in = phase_ff;
      ent_in   = ent_ff;
      acc_in   = acc_ff;
      upd_in   = upd_ff;
      hit_in   = hit_ff;
      out_in   = out_ff;
      go_state = ST_FIN;
      ram_we    = 1'b0;
      ram_waddr = req_ff.index;
      ram_wdata = ram_rdata;
      in_rng  = CntW'(req_data.index) < count_ff;
      last    = (CntW'(ptr_ff) + CntW'(1)) == count_ff;
      so      = !cmp.a_lt_s && (cmp.a_lt_e || cmp.a_eq_e);
      eo      = !cmp.b_lt_s && (cmp.b_lt_e || cmp.b_eq_e);
      enc     = (cmp.a_lt_s || cmp.a_eq_s) && !cmp.b_lt_e;
      code_nx = code_ff;
      pos_nx  = pos_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               req_in   = req_data;
               acc_in   = 1'b0;
               upd_in   = 1'b0;
               code_in  = CONF_NONE;
               hit_in   = '0;
               out_in   = '0;
               phase_in = 1'b0;
               found_in = 1'b0;
               ptr_in   = req_data.index;
               case (req_data.op) inside
                  OP_ADD: begin
                     if (req_data.start_time < req_data.end_time &&
                         count_ff != CntW'(MaxEntries)) begin
                        pos_in = count_ff[AddrW-1:0];
                        ptr_in = '0;
                        go_state = (count_ff == '0) ? ST_WR : ST_RD;
                     end
                  end
                  OP_REMOVE: begin
                     if (in_rng) begin
                        acc_in = 1'b1;
                        upd_in = 1'b1;
                        if (CntW'(req_data.index) + CntW'(1) < count_ff) begin
                           go_state = ST_SHRD;
                        end else begin
                           count_in = count_ff - CntW'(1);
                        end
                     end
                  end
                  OP_CLEAR: begin
                     count_in = '0;
                     acc_in   = 1'b1;
                     upd_in   = 1'b1;
                  end
                  OP_LOOKUP: begin
                     ptr_in = '0;
                     if (count_ff != '0) go_state = ST_RD;
                  end
                  OP_SET_START, OP_SET_END, OP_SET_DOWN, OP_SET_UP,
                  OP_SET_PAUSE, OP_READ: begin
                     if (in_rng) go_state = ST_RD;
                  end
                  default: go_state = ST_FIN;
               endcase
            end
         end

         ST_EV: begin
            case (req_ff.op)
               // overlap scan and insert position search
               OP_ADD: begin
                  if (enc || (so && eo) || (code_ff == CONF_END && so) ||
                      (code_ff == CONF_START && eo)) begin
                     code_in = CONF_BOTH;
                  end else begin
                     if (so) code_nx = CONF_START;
                     else if (eo) code_nx = CONF_END;
                     if (!found_ff && cmp.a_lt_s) begin
                        pos_nx   = ptr_ff;
                        found_in = 1'b1;
                     end
                     code_in = code_nx;
                     pos_in  = pos_nx;
                     if (!last) begin
                        ptr_in   = AddrW'(ptr_ff + AddrW'(1));
                        go_state = ST_RD;
                     end else if (code_nx == CONF_NONE) begin
                        if (CntW'(pos_nx) == count_ff) begin
                           go_state = ST_WR;
                        end else begin
                           ptr_in   = AddrW'(count_ff - CntW'(1));
                           go_state = ST_SHRD;
                        end
                     end
                  end
               end
               OP_LOOKUP: begin
                  if (!cmp.a_lt_s && cmp.a_lt_e) begin
                     acc_in = 1'b1;
                     hit_in = ptr_ff;
                     out_in = ram_rdata;
                  end else if (!last) begin
                     ptr_in   = AddrW'(ptr_ff + AddrW'(1));
                     go_state = ST_RD;
                  end
               end
               OP_READ: begin
                  acc_in = 1'b1;
                  out_in = ram_rdata;
               end
               OP_SET_DOWN: begin
                  acc_in = 1'b1;
                  ram_wdata.down = req_ff.download_speed;
                  if (ram_rdata.down != req_ff.download_speed) begin
                     ram_we = 1'b1;
                     upd_in = 1'b1;
                  end
               end
               OP_SET_UP: begin
                  acc_in = 1'b1;
                  ram_wdata.up = req_ff.upload_speed;
                  if (ram_rdata.up != req_ff.upload_speed) begin
                     ram_we = 1'b1;
                     upd_in = 1'b1;
                  end
               end
               OP_SET_PAUSE: begin
                  acc_in = 1'b1;
                  ram_wdata.pause = req_ff.pause_flag;
                  if (ram_rdata.pause != req_ff.pause_flag) begin
                     ram_we = 1'b1;
                     upd_in = 1'b1;
                  end
               end
               // start edit, guarded by own end and previous end
               OP_SET_START: begin
                  if (!phase_ff) begin
                     ent_in = ram_rdata;
                     ram_wdata.start_ms = req_ff.start_time;
                     if (cmp.a_eq_s) begin
                        acc_in = 1'b1;
                     end else if (cmp.a_lt_e) begin
                        if (req_ff.index == '0) begin
                           ram_we = 1'b1;
                           acc_in = 1'b1;
                           upd_in = 1'b1;
                        end else begin
                           phase_in = 1'b1;
                           ptr_in   = AddrW'(req_ff.index - AddrW'(1));
                           go_state = ST_RD;
                        end
                     end
                  end else begin
                     ram_wdata = ent_ff;
                     ram_wdata.start_ms = req_ff.start_time;
                     if (!cmp.a_lt_e && !cmp.a_eq_e) begin
                        ram_we = 1'b1;
                        acc_in = 1'b1;
                        upd_in = 1'b1;
                     end
                  end
               end
               // end edit, guarded by own start and next start
               OP_SET_END: begin
                  if (!phase_ff) begin
                     ent_in = ram_rdata;
                     ram_wdata.end_ms = req_ff.end_time;
                     if (cmp.b_eq_e) begin
                        acc_in = 1'b1;
                     end else if (!cmp.b_lt_s && !cmp.b_eq_s) begin
                        if (CntW'(req_ff.index) + CntW'(1) == count_ff) begin
                           ram_we = 1'b1;
                           acc_in = 1'b1;
                           upd_in = 1'b1;
                        end else begin
                           phase_in = 1'b1;
                           ptr_in   = AddrW'(req_ff.index + AddrW'(1));
                           go_state = ST_RD;
                        end
                     end
                  end else begin
                     ram_wdata = ent_ff;
                     ram_wdata.end_ms = req_ff.end_time;
                     if (cmp.b_lt_s) begin
                        ram_we = 1'b1;
                        acc_in = 1'b1;
                        upd_in = 1'b1;
                     end
                  end
               end
               default: go_state = ST_FIN;
            endcase
         end

         // move one entry per pass
         ST_SHWR: begin
            ram_we    = 1'b1;
            ram_wdata = ram_rdata;
            if (req_ff.op == OP_ADD) begin
               ram_waddr = AddrW'(ptr_ff + AddrW'(1));
               if (ptr_ff == pos_ff) begin
                  go_state = ST_WR;
               end else begin
                  ptr_in   = AddrW'(ptr_ff - AddrW'(1));
                  go_state = ST_SHRD;
               end
            end else begin
               ram_waddr = ptr_ff;
               ptr_in    = AddrW'(ptr_ff + AddrW'(1));
               if (CntW'(ptr_ff) + CntW'(2) < count_ff) begin
                  go_state = ST_SHRD;
               end else begin
                  count_in = count_ff - CntW'(1);
               end
            end
         end

         // insert the new entry
         ST_WR: begin
            ram_we    = 1'b1;
            ram_waddr = pos_ff;
            ram_wdata.start_ms = req_ff.start_time;
            ram_wdata.end_ms   = req_ff.end_time;
            ram_wdata.down     = req_ff.download_speed;
            ram_wdata.up       = req_ff.upload_speed;
            ram_wdata.pause    = req_ff.pause_flag;
            count_in = count_ff + CntW'(1);
            acc_in   = 1'b1;
            upd_in   = 1'b1;
         end

         default: go_state = ST_FIN;
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (req_valid) state_in = go_state;
         ST_RD:   state_in = ST_EV;
         ST_EV:   state_in = go_state;
         ST_SHRD: state_in = ST_SHWR;
         ST_SHWR: state_in = go_state;
         ST_WR:   state_in = ST_FIN;
         ST_FIN:  if (!rsp_valid_ff || !rsp_stall) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         if (state_ff == ST_FIN && (!rsp_valid_ff || !rsp_stall)) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      req_ff   <= req_in;
      ptr_ff   <= ptr_in;
      pos_ff   <= pos_in;
      found_ff <= found_in;
      code_ff  <= code_in;
      phase_ff <= phase_in;
      ent_ff   <= ent_in;
      acc_ff   <= acc_in;
      upd_ff   <= upd_in;
      hit_ff   <= hit_in;
      out_ff   <= out_in;
      if (state_ff == ST_FIN && (!rsp_valid_ff || !rsp_stall)) begin
         rsp_data_ff.accepted     <= acc_ff;
         rsp_data_ff.conflict     <= code_ff;
         rsp_data_ff.updated      <= upd_ff;
         rsp_data_ff.hit_index    <= hit_ff;
         rsp_data_ff.entry_count  <= count_ff;
         rsp_data_ff.out_start    <= out_ff.start_ms;
         rsp_data_ff.out_end      <= out_ff.end_ms;
         rsp_data_ff.out_download <= out_ff.down;
         rsp_data_ff.out_upload   <= out_ff.up;
         rsp_data_ff.out_pause    <= out_ff.pause;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef NO_ASSERTIONS
   ast_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CntW'(MaxEntries))
      else $error("entry count beyond table size");
   ast_upd_acc: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (!rsp_data_ff.updated || rsp_data_ff.accepted))
      else $error("update reported on rejected operation");
   ast_conf_rej: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (!rsp_data_ff.accepted || rsp_data_ff.conflict == CONF_NONE))
      else $error("accepted operation carries a conflict");
   ast_count_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE && !req_valid) |=> $stable(count_ff))
      else $error("entry count changed while idle");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/trst_ram.sv =====
// trst_ram: generic single write, single read RAM with registered read
// no dependencies
`default_nettype none

module trst_ram #(
   parameter int Width = 8,
   parameter int Depth = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(Depth)-1:0] wr_addr,
   input  wire logic [Width-1:0]         wr_data,
   input  wire logic [$clog2(Depth)-1:0] rd_addr,
   output logic      [Width-1:0]         rd_data
);

   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/trst_cmp.sv =====
// trst_cmp: shared time compare unit, two probes against one entry's range
// depends on trst_pkg
`default_nettype none

module trst_cmp
   import trst_pkg::*;
(
   input  wire logic [TimeW-1:0] probe_a,
   input  wire logic [TimeW-1:0] probe_b,
   input  wire logic [TimeW-1:0] ent_start,
   input  wire logic [TimeW-1:0] ent_end,
   output cmp_type               flags
);

   // four magnitude compares, each giving less and equal
   always_comb begin
      flags.a_lt_s = probe_a < ent_start;
      flags.a_eq_s = probe_a == ent_start;
      flags.a_lt_e = probe_a < ent_end;
      flags.a_eq_e = probe_a == ent_end;
      flags.b_lt_s = probe_b < ent_start;
      flags.b_eq_s = probe_b == ent_start;
      flags.b_lt_e = probe_b < ent_end;
      flags.b_eq_e = probe_b == ent_end;
   end

endmodule

`default_nettype wire

// ===== tb/sv/time_range_schedule_table_checker.sv =====
// time_range_schedule_table_checker: watches request and result transfers of the
// schedule table, predicts each result and compares it field by field
// depends on trst_pkg
`timescale 1ns / 100ps
`default_nettype none

module time_range_schedule_table_checker
   import trst_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   input  wire logic    req_stall,
   input  wire req_type req_data,
   input  wire logic    rsp_valid,
   input  wire logic    rsp_stall,
   input  wire rsp_type rsp_data,
   output int           fail_count,
   output int           pending_count
);

   // shadow copy of the table
   entry_type       shadow_tab [MaxEntries];
   int unsigned     shadow_cnt;
   rsp_type         pending_rsp [$];

   // overlap code with inclusive endpoints
   function automatic logic [1:0] overlap_of(logic [TimeW-1:0] s, logic [TimeW-1:0] e);
      logic [1:0] code;
      logic so, eo, enc;
      code = CONF_NONE;
      for (int i = 0; i < shadow_cnt; i++) begin
         so  = s >= shadow_tab[i].start_ms && s <= shadow_tab[i].end_ms;
         eo  = e >= shadow_tab[i].start_ms && e <= shadow_tab[i].end_ms;
         enc = s <= shadow_tab[i].start_ms && e >= shadow_tab[i].end_ms;
         if (enc || (so && eo)) return CONF_BOTH;
         if (code == CONF_END && so) return CONF_BOTH;
         if (code == CONF_START && eo) return CONF_BOTH;
         if (so) code = CONF_START;
         else if (eo) code = CONF_END;
      end
      return code;
   endfunction

   // apply one operation to the shadow table and form its result
   function automatic rsp_type schedule_step(req_type r);
      rsp_type   o;
      int        pos;
      logic      in_rng;
      entry_type ent;
      o = '0;
      in_rng = r.index < shadow_cnt;
      case (r.op)
         OP_ADD: begin
            if (r.start_time < r.end_time && shadow_cnt < MaxEntries) begin
               o.conflict = overlap_of(r.start_time, r.end_time);
               if (o.conflict == CONF_NONE) begin
                  pos = shadow_cnt;
                  for (int i = 0; i < shadow_cnt; i++)
                     if (shadow_tab[i].start_ms > r.start_time) begin
                        pos = i;
                        break;
                     end
                  for (int i = shadow_cnt; i > pos; i--) shadow_tab[i] = shadow_tab[i-1];
                  ent.start_ms = r.start_time;
                  ent.end_ms   = r.end_time;
                  ent.down     = r.download_speed;
                  ent.up       = r.upload_speed;
                  ent.pause    = r.pause_flag;
                  shadow_tab[pos] = ent;
                  shadow_cnt++;
                  o.accepted = 1;
                  o.updated  = 1;
               end
            end
         end
         OP_REMOVE: if (in_rng) begin
            for (int i = r.index; i + 1 < shadow_cnt; i++) shadow_tab[i] = shadow_tab[i+1];
            shadow_cnt--;
            o.accepted = 1;
            o.updated  = 1;
         end
         OP_CLEAR: begin
            shadow_cnt = 0;
            o.accepted = 1;
            o.updated  = 1;
         end
         OP_SET_START: if (in_rng) begin
            if (shadow_tab[r.index].start_ms == r.start_time) o.accepted = 1;
            else if (r.start_time < shadow_tab[r.index].end_ms &&
                     (r.index == 0 || r.start_time > shadow_tab[r.index-1].end_ms)) begin
               shadow_tab[r.index].start_ms = r.start_time;
               o.accepted = 1;
               o.updated  = 1;
            end
         end
         OP_SET_END: if (in_rng) begin
            if (shadow_tab[r.index].end_ms == r.end_time) o.accepted = 1;
            else if (r.end_time > shadow_tab[r.index].start_ms &&
                     (r.index + 1 == shadow_cnt ||
                      r.end_time < shadow_tab[r.index+1].start_ms)) begin
               shadow_tab[r.index].end_ms = r.end_time;
               o.accepted = 1;
               o.updated  = 1;
            end
         end
         OP_SET_DOWN: if (in_rng) begin
            o.accepted = 1;
            o.updated  = shadow_tab[r.index].down != r.download_speed;
            shadow_tab[r.index].down = r.download_speed;
         end
         OP_SET_UP: if (in_rng) begin
            o.accepted = 1;
            o.updated  = shadow_tab[r.index].up != r.upload_speed;
            shadow_tab[r.index].up = r.upload_speed;
         end
         OP_SET_PAUSE: if (in_rng) begin
            o.accepted = 1;
            o.updated  = shadow_tab[r.index].pause != r.pause_flag;
            shadow_tab[r.index].pause = r.pause_flag;
         end
         OP_LOOKUP: begin
            for (int i = 0; i < shadow_cnt; i++)
               if (r.now_time >= shadow_tab[i].start_ms && r.now_time < shadow_tab[i].end_ms) begin
                  o.accepted  = 1;
                  o.hit_index = AddrW'(i);
                  pos = i;
                  break;
               end
            if (o.accepted) begin
               o.out_start    = shadow_tab[pos].start_ms;
               o.out_end      = shadow_tab[pos].end_ms;
               o.out_download = shadow_tab[pos].down;
               o.out_upload   = shadow_tab[pos].up;
               o.out_pause    = shadow_tab[pos].pause;
            end
         end
         OP_READ: if (in_rng) begin
            o.accepted     = 1;
            o.out_start    = shadow_tab[r.index].start_ms;
            o.out_end      = shadow_tab[r.index].end_ms;
            o.out_download = shadow_tab[r.index].down;
            o.out_upload   = shadow_tab[r.index].up;
            o.out_pause    = shadow_tab[r.index].pause;
         end
         default: ;
      endcase
      o.entry_count = CntW'(shadow_cnt);
      return o;
   endfunction

   // predict on request transfers, compare on result transfers
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         shadow_cnt = 0;
         fail_count    <= 0;
         pending_count <= 0;
         pending_rsp.delete();
      end else begin
         if (req_valid && !req_stall) pending_rsp.push_back(schedule_step(req_data));
         if (rsp_valid && !rsp_stall) begin
            if (pending_rsp.size() == 0) begin
               $error("result transfer with nothing expected");
               fail_count <= fail_count + 1;
            end else begin
               want = pending_rsp.pop_front();
               if (want !== rsp_data) begin
                  fail_count <= fail_count + 1;
                  if (want.accepted !== rsp_data.accepted)
                     $error("accepted exp %0d got %0d", want.accepted, rsp_data.accepted);
                  if (want.conflict !== rsp_data.conflict)
                     $error("conflict exp %0d got %0d", want.conflict, rsp_data.conflict);
                  if (want.updated !== rsp_data.updated)
                     $error("updated exp %0d got %0d", want.updated, rsp_data.updated);
                  if (want.hit_index !== rsp_data.hit_index)
                     $error("hit_index exp %0d got %0d", want.hit_index, rsp_data.hit_index);
                  if (want.entry_count !== rsp_data.entry_count)
                     $error("entry_count exp %0d got %0d", want.entry_count,
                            rsp_data.entry_count);
                  if (want.out_start !== rsp_data.out_start)
                     $error("out_start exp %0d got %0d", want.out_start, rsp_data.out_start);
                  if (want.out_end !== rsp_data.out_end)
                     $error("out_end exp %0d got %0d", want.out_end, rsp_data.out_end);
                  if (want.out_download !== rsp_data.out_download)
                     $error("out_download exp %0d got %0d", want.out_download,
                            rsp_data.out_download);
                  if (want.out_upload !== rsp_data.out_upload)
                     $error("out_upload exp %0d got %0d", want.out_upload,
                            rsp_data.out_upload);
                  if (want.out_pause !== rsp_data.out_pause)
                     $error("out_pause exp %0d got %0d", want.out_pause, rsp_data.out_pause);
               end
            end
         end
         pending_count <= pending_rsp.size();
      end
   end

endmodule

`default_nettype wire

// ===== tb/sv/time_range_schedule_table_unit_tb.sv =====
// time_range_schedule_table_unit_tb: drives directed and random table operations
// with random gaps and stalls; depends on trst_pkg, the block and the checker
`timescale 1ns / 100ps
`default_nettype none

module time_range_schedule_table_unit_tb;
   import trst_pkg::*;

   localparam int unsigned DayMs = 86400000;

   logic    clock = 0;
   logic    reset = 1;
   logic    req_valid = 0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 0;
   rsp_type rsp_data;
   int      fail_count;
   int      pending_count;

   time_range_schedule_table_unit u_top (.*);

   time_range_schedule_table_checker u_check (.*);

   // clock
   initial begin
      forever #2 clock = ~clock;
   end

   // run limit
   initial begin
      #20ms;
      $display("Regression FAIL");
      $finish;
   end

   // result side stall, held for a random time before each transfer or not at all
   initial begin
      int hold;
      @(posedge clock iff !reset);
      forever begin
         hold = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
         if (hold > 0) begin
            rsp_stall <= 1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 0;
         @(posedge clock iff rsp_valid);
      end
   end

   function automatic logic [TimeW-1:0] rand_ms();
      return TimeW'($urandom_range(0, DayMs - 1));
   endfunction

   function automatic logic [SpeedW-1:0] rand_speed();
      case ($urandom_range(0, 3))
         0: return '0;
         1: return 31'h7FFF_FFFF;
         2: return SpeedW'($urandom_range(0, 15));
         default: return SpeedW'($urandom);
      endcase
   endfunction

   // one transfer with a random gap ahead of it
   task automatic send_op(req_type r, bit no_gap = 0);
      int gap;
      gap = no_gap ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1;
      req_data  <= r;
      @(posedge clock iff !req_stall);
   endtask

   task automatic send_fields(logic [3:0] op, logic [3:0] idx, logic [TimeW-1:0] s,
                              logic [TimeW-1:0] e, logic [SpeedW-1:0] dn,
                              logic [SpeedW-1:0] up, logic pz, logic [TimeW-1:0] now);
      req_type r;
      r = '{op, idx, s, e, dn, up, pz, now};
      send_op(r, $urandom_range(0, 4) == 0);
   endtask

   // random operation, mostly well formed against a table of a slot grid
   task automatic random_op();
      logic [3:0]       op;
      logic [TimeW-1:0] s, e;
      int               slot;
      slot = $urandom_range(0, 23);
      s = TimeW'(slot * 3600000 + $urandom_range(0, 1000));
      e = TimeW'(s + $urandom_range(1, 3600000 - 2000));
      if ($urandom_range(0, 7) == 0) begin
         s = rand_ms();
         e = rand_ms();
      end
      case ($urandom_range(0, 19))
         0, 1, 2, 3, 4, 5: op = OP_ADD;
         6:       op = ($urandom_range(0, 3) == 0) ? OP_CLEAR : OP_REMOVE;
         7:       op = OP_REMOVE;
         8, 9:    op = OP_SET_START;
         10, 11:  op = OP_SET_END;
         12:      op = OP_SET_DOWN;
         13:      op = OP_SET_UP;
         14:      op = OP_SET_PAUSE;
         15, 16:  op = OP_LOOKUP;
         17, 18:  op = OP_READ;
         default: op = 4'($urandom_range(10, 15));
      endcase
      send_fields(op, 4'($urandom), s, e, rand_speed(), rand_speed(), 1'($urandom),
                  rand_ms());
   endtask

   // stimulus and verdict
   initial begin
      int drain;
      repeat (11) @(posedge clock);
      reset <= 0;
      // directed part: empty-table cases, extremes, each op, full table
      send_fields(OP_READ, 0, 0, 0, 0, 0, 0, 0);
      send_fields(OP_LOOKUP, 0, 0, 0, 0, 0, 0, TimeW'(DayMs - 1));
      send_fields(OP_ADD, 0, 5, 5, 0, 0, 0, 0);
      send_fields(OP_ADD, 0, 9, 3, 0, 0, 0, 0);
      send_fields(OP_ADD, 15, 0, TimeW'(DayMs - 1), 31'h7FFF_FFFF, 31'h7FFF_FFFF, 1, 0);
      send_fields(OP_LOOKUP, 0, 0, 0, 0, 0, 0, TimeW'(DayMs - 1));
      send_fields(OP_LOOKUP, 0, 0, 0, 0, 0, 0, 0);
      send_fields(OP_READ, 0, 0, 0, 0, 0, 0, 0);
      send_fields(OP_SET_DOWN, 0, 0, 0, 31'h7FFF_FFFF, 0, 0, 0);
      send_fields(OP_SET_UP, 0, 0, 0, 0, 0, 0, 0);
      send_fields(OP_SET_PAUSE, 0, 0, 0, 0, 0, 0, 0);
      send_fields(OP_SET_START, 0, 0, 0, 0, 0, 0, 0);
      send_fields(OP_SET_END, 0, 0, 1000, 0, 0, 0, 0);
      send_fields(OP_SET_START, 1, 0, 0, 0, 0, 0, 0);
      send_fields(OP_ADD, 0, 1000, 2000, 1, 2, 0, 0);
      send_fields(OP_ADD, 0, 500, 1500, 1, 2, 0, 0);
      send_fields(OP_REMOVE, 0, 0, 0, 0, 0, 0, 0);
      send_fields(4'd15, 15, 0, 0, 0, 0, 1, 0);
      // fill to the saturation limit, then one more
      for (int i = 0; i <= MaxEntries; i++)
         send_fields(OP_ADD, 0, TimeW'(i * 1000000 + 1), TimeW'(i * 1000000 + 900000),
                     SpeedW'($urandom), SpeedW'($urandom), 1'($urandom), 0);
      send_fields(OP_READ, 15, 0, 0, 0, 0, 0, 0);
      send_fields(OP_CLEAR, 0, 0, 0, 0, 0, 0, 0);
      // random part, with clears now and then so adds keep succeeding
      for (int n = 0; n < 1750; n++) begin
         if ($urandom_range(0, 59) == 0)
            send_fields(OP_CLEAR, 4'($urandom), 0, 0, 0, 0, 0, 0);
         random_op();
      end
      req_valid <= 0;
      drain = 0;
      while (pending_count != 0 && drain < 100000) begin
         @(posedge clock);
         drain++;
      end
      repeat (100) @(posedge clock);
      if (fail_count == 0 && pending_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

`default_nettype wire

// ===== filelist.f =====
hw/rtl/trst_pkg.sv
hw/rtl/trst_ram.sv
hw/rtl/trst_cmp.sv
hw/rtl/time_range_schedule_table_unit.sv
tb/sv/time_range_schedule_table_checker.sv
tb/sv/time_range_schedule_table_unit_tb.sv
